@@ rtl/core/ibfcd_pkg.sv @@
// ----------------------------------------------------------------------------
// ibfcd_pkg
// Shared types, constants and the control store of the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ibfcd_pkg;

  // Frame layout
  localparam logic [7:0]  HDR_FIRST    = 8'h20;
  localparam logic [7:0]  HDR_SECOND   = 8'h40;
  localparam logic [15:0] CK_AFTER_HDR = 16'hFF9F;
  localparam logic [15:0] CK_INIT      = 16'hFFFF;
  localparam int unsigned PAYLOAD_LEN  = 28;
  localparam int unsigned FRAME_LEN    = 30;
  localparam int unsigned STORE_AW     = $clog2(FRAME_LEN);
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned CHAN_W       = 5;
  localparam int unsigned VAL_W        = 12;

  // Program counter and fixed program locations
  localparam int unsigned PC_W = 6;
  localparam logic [PC_W-1:0] PC_WAIT = 6'd0;
  localparam logic [PC_W-1:0] PC_BYTE = 6'd1;
  localparam logic [PC_W-1:0] PC_CK0  = 6'd2;
  localparam logic [PC_W-1:0] PC_CK1  = 6'd3;
  localparam logic [PC_W-1:0] PC_CK2  = 6'd4;
  localparam logic [PC_W-1:0] PC_DATA = 6'd5;
  localparam logic [PC_W-1:0] PC_NIB  = 6'd33;
  localparam logic [PC_W-1:0] PC_LAST = 6'd44;
  localparam logic [PC_W-1:0] PC_ERR  = 6'd45;

  // Checksum word location in the store
  localparam logic [STORE_AW-1:0] ADDR_CK_LO = 5'd28;
  localparam logic [STORE_AW-1:0] ADDR_CK_HI = 5'd29;

  // Step kinds
  typedef enum logic [1:0] {
    K_WAIT,
    K_BYTE,
    K_STEP
  } kind_e;

  // How the read data of the previous step is merged
  typedef enum logic [2:0] {
    M_NONE,
    M_LO,
    M_HI,
    M_N0,
    M_N1,
    M_N2,
    M_CKLO,
    M_CKHI
  } merge_e;

  // Jump conditions
  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NOT_DONE,
    JC_CK_BAD
  } jcond_e;

  typedef struct packed {
    kind_e               kind;
    logic [STORE_AW-1:0] addr;
    merge_e              merge;
    logic                emit;
    logic                status;
    logic                last;
    logic [CHAN_W-1:0]   chan;
    jcond_e              cond;
    logic [PC_W-1:0]     target;
  } ctrl_t;

  // Control store: one control word per step
  function automatic ctrl_t ctrl_rom(input logic [PC_W-1:0] pc);
    ctrl_t           c;
    logic [PC_W-1:0] rel;
    c = '{kind: K_STEP, addr: '0, merge: M_NONE, emit: 1'b0, status: 1'b0,
          last: 1'b0, chan: '0, cond: JC_NEXT, target: PC_WAIT};
    rel = '0;
    if (pc == PC_WAIT) begin
      c.kind = K_WAIT;
    end else if (pc == PC_BYTE) begin
      c.kind   = K_BYTE;
      c.cond   = JC_NOT_DONE;
      c.target = PC_WAIT;
    end else if (pc == PC_CK0) begin
      c.addr = ADDR_CK_LO;
    end else if (pc == PC_CK1) begin
      c.addr  = ADDR_CK_HI;
      c.merge = M_CKLO;
    end else if (pc == PC_CK2) begin
      c.addr   = '0;
      c.merge  = M_CKHI;
      c.cond   = JC_CK_BAD;
      c.target = PC_ERR;
    end else if (pc >= PC_DATA && pc < PC_NIB) begin
      // byte-pair channels: low byte step, then high nibble step with emit
      rel    = pc - PC_DATA;
      c.chan = CHAN_W'(rel[PC_W-1:1]);
      c.emit = rel[0];
      c.merge = rel[0] ? M_HI : M_LO;
      // last pair step fetches the first byte of the nibble channels
      c.addr = (rel == 6'd27) ? 5'd1 : STORE_AW'(rel + 6'd1);
    end else if (pc >= PC_NIB && pc <= PC_LAST) begin
      // nibble channels: three high nibbles each
      rel    = pc - PC_NIB;
      c.addr = STORE_AW'((rel << 1) + 6'd3);
      case (rel)
        6'd0, 6'd3, 6'd6, 6'd9: begin
          c.merge = M_N0;
        end
        6'd1, 6'd4, 6'd7, 6'd10: begin
          c.merge = M_N1;
        end
        6'd2: begin
          c.merge = M_N2; c.emit = 1'b1; c.chan = 5'd14;
        end
        6'd5: begin
          c.merge = M_N2; c.emit = 1'b1; c.chan = 5'd15;
        end
        6'd8: begin
          c.merge = M_N2; c.emit = 1'b1; c.chan = 5'd16;
        end
        6'd11: begin
          c.merge = M_N2; c.emit = 1'b1; c.chan = 5'd17;
          c.last = 1'b1; c.cond = JC_ALWAYS; c.target = PC_WAIT;
          c.addr = '0;
        end
        default: begin
          c.merge = M_NONE;
        end
      endcase
    end else if (pc == PC_ERR) begin
      c.emit   = 1'b1;
      c.status = 1'b1;
      c.last   = 1'b1;
      c.cond   = JC_ALWAYS;
      c.target = PC_WAIT;
    end else begin
      // unused locations return home
      c.cond   = JC_ALWAYS;
      c.target = PC_WAIT;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ibus_frame_channel_decoder_top.sv @@
// ----------------------------------------------------------------------------
// ibus_frame_channel_decoder_top
// Serial frame decoder for 18 channels, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per item on rx_byte_i (in_valid_i /
//   in_stall_o). The pair 0x20,0x40 opens a frame at any time; 30 further
//   bytes follow (28 payload, checksum word low byte first).
//   Output channel: result items on status_o, channel_index_o,
//   channel_value_o, last_o (out_valid_o / out_stall_i).
//   Each byte passes an accept step, then an update step. After the 30th
//   byte of a frame is accepted, the read-out program runs its checksum read
//   steps, then on a match emits 18 results: a low byte step and a high nibble
//   step for each of channels 0..13, and for channels 14..17 a nibble step per
//   gathered high nibble; on a mismatch it emits one error item. The single
//   read port of the frame store sets the read-out pace: one byte fetched per step.
//   A stalled receiver holds the result in the output register; the
//   sequencer waits on an emit step until the register frees up, and bytes
//   are not taken during a read-out.
//   Reset clears the sequencer, the frame state and the previous-byte
//   register; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ibus_frame_channel_decoder_top
  import ibfcd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   status_o,
  output logic [CHAN_W-1:0]      channel_index_o,
  output logic [VAL_W-1:0]       channel_value_o,
  output logic                   last_o
);

  ctrl_t               ctrl;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic [BYTE_W-1:0]   byte_q;
  logic [BYTE_W-1:0]   prev_q, prev_d;
  logic                in_frame_q, in_frame_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [15:0]         ck_q, ck_d;
  logic [VAL_W-1:0]    acc_q, acc_d;
  logic [BYTE_W-1:0]   cw_lo_q, cw_lo_d;
  logic [BYTE_W-1:0]   rdata;
  logic                hdr, done, ck_bad, take, advance, can_load, in_acc;
  logic                st_we;

  // current control word
  assign ctrl       = ctrl_rom(pc_q);
  assign in_stall_o = (ctrl.kind != K_WAIT);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign can_load   = !out_valid_o || !out_stall_i;

  // step advance: wait for a byte, or for room in the output register
  always_comb begin
    case (ctrl.kind)
      K_WAIT:  advance = in_acc;
      K_BYTE:  advance = 1'b1;
      K_STEP:  advance = !ctrl.emit || can_load;
      default: advance = 1'b1;
    endcase
  end

  // byte update: header detect, store write, running checksum
  assign hdr = (prev_q == HDR_FIRST) && (byte_q == HDR_SECOND);

  always_comb begin
    prev_d     = prev_q;
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    ck_d       = ck_q;
    done       = 1'b0;
    st_we      = 1'b0;
    if (ctrl.kind == K_BYTE) begin
      prev_d = byte_q;
      if (hdr) begin
        in_frame_d = 1'b1;
        cnt_d      = '0;
        ck_d       = CK_AFTER_HDR;
      end else if (in_frame_q) begin
        st_we = 1'b1;
        if (cnt_q < CNT_W'(PAYLOAD_LEN)) begin
          ck_d = ck_q - {8'h00, byte_q};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FRAME_LEN - 1)) begin
          done       = 1'b1;
          in_frame_d = 1'b0;
          cnt_d      = '0;
        end
      end
    end
  end

  // frame store
  ibfcd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (cnt_q),
    .wdata_i (byte_q),
    .re_i    (advance && (ctrl.kind == K_STEP)),
    .raddr_i (ctrl.addr),
    .rdata_o (rdata)
  );

  // merge the byte fetched by the previous step
  always_comb begin
    acc_d   = acc_q;
    cw_lo_d = cw_lo_q;
    case (ctrl.merge)
      M_LO:    acc_d   = {4'h0, rdata};
      M_HI:    acc_d   = {rdata[3:0], acc_q[7:0]};
      M_N0:    acc_d   = {acc_q[11:4], rdata[7:4]};
      M_N1:    acc_d   = {acc_q[11:8], rdata[7:4], acc_q[3:0]};
      M_N2:    acc_d   = {rdata[7:4], acc_q[7:0]};
      M_CKLO:  cw_lo_d = rdata;
      default: acc_d   = acc_q;
    endcase
  end

  assign ck_bad = (ctrl.merge == M_CKHI) && ({rdata, cw_lo_q} != ck_q);

  // sequencer next step
  always_comb begin
    case (ctrl.cond)
      JC_ALWAYS:   take = 1'b1;
      JC_NOT_DONE: take = !done;
      JC_CK_BAD:   take = ck_bad;
      default:     take = 1'b0;
    endcase
    pc_d = pc_q;
    if (advance) begin
      pc_d = take ? ctrl.target : pc_q + 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= PC_WAIT;
      prev_q     <= '0;
      in_frame_q <= 1'b0;
      cnt_q      <= '0;
      ck_q       <= CK_INIT;
    end else begin
      pc_q       <= pc_d;
      prev_q     <= prev_d;
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      ck_q       <= ck_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= rx_byte_i;
    end
    if (advance) begin
      acc_q   <= acc_d;
      cw_lo_q <= cw_lo_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ctrl.emit && advance && (ctrl.kind == K_STEP)) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit && advance && (ctrl.kind == K_STEP)) begin
      status_o        <= ctrl.status;
      channel_index_o <= ctrl.chan;
      channel_value_o <= ctrl.status ? '0 : acc_d;
      last_o          <= ctrl.last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ibfcd_ram.sv @@
// ----------------------------------------------------------------------------
// ibfcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ibfcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 30
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ibfcd_checker.sv @@
// ----------------------------------------------------------------------------
// ibfcd_checker
// Port-level checks on the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ibfcd_checker
  import ibfcd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              status_o,
  input wire logic [CHAN_W-1:0] channel_index_o,
  input wire logic [VAL_W-1:0]  channel_value_o,
  input wire logic              last_o
);

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped under stall");

  // a stalled item keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(channel_value_o) && $stable(channel_index_o)
      && $stable(status_o) && $stable(last_o))
    else $error("result payload changed under stall");

  // an error item is a lone closing item with cleared fields
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o && (channel_index_o == '0)
      && (channel_value_o == '0))
    else $error("malformed error item");

  // channel numbers stay in range
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (channel_index_o <= CHAN_W'(17)))
    else $error("channel index out of range");

  // the closing item of a frame is not followed straight away by another
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o)
    else $error("result right after the closing item");

endmodule

bind ibus_frame_channel_decoder_top ibfcd_checker u_ibfcd_checker (.*);

`default_nettype wire

@@ tb/tb_ibus_frame_channel_decoder_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ibus_frame_channel_decoder_top
// Self-checking bench for the 18-channel serial frame decoder. Bytes go in
// through the valid/stall input. A frame tracker predicts the channel items
// of every frame, and each output item is compared against them. Traffic
// runs under varied idling, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------

module tb_ibus_frame_channel_decoder_top;
  import ibfcd_pkg::*;

  localparam int CLK_HIGH      = 6;
  localparam int CLK_LOW       = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int NUM_CHANNELS  = 18;
  localparam int PAIR_CHANNELS = 14;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 120;
  // the long hold-off is the longest quiet stretch; allow it several times over
  localparam int QUIET_LIMIT   = 3000;

  typedef struct packed {
    logic              status;
    logic [CHAN_W-1:0] chan;
    logic [VAL_W-1:0]  value;
    logic              last;
  } chan_item_t;

  // DUT connections
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [BYTE_W-1:0] rx_byte_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              status_o;
  logic [CHAN_W-1:0] channel_index_o;
  logic [VAL_W-1:0]  channel_value_o;
  logic              last_o;

  // frame tracker state
  logic [BYTE_W-1:0] rx_prev = '0;
  logic              frame_open = 1'b0;
  int                frame_pos = 0;
  logic [15:0]       frame_sum = CK_INIT;
  logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];

  chan_item_t        pending_channels [$];
  chan_item_t        head_item;
  logic [BYTE_W-1:0] payload_buf [PAYLOAD_LEN];

  // run control and tallies
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_requests  = 0;
  int holds_done     = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int fail_count     = 0;
  int items_sent     = 0;
  int items_checked  = 0;
  int good_frames    = 0;
  int bad_frames     = 0;

  ibus_frame_channel_decoder_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .channel_index_o(channel_index_o),
    .channel_value_o(channel_value_o),
    .last_o         (last_o)
  );

  // Clock
  always begin
    #CLK_HIGH clk_i = 1'b1;
    #CLK_LOW  clk_i = 1'b0;
  end

  // Receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (holds_done != hold_requests) begin
      holds_done = hold_requests;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Watchdog: cycles without any accepted item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no item accepted for %0d cycles", QUIET_LIMIT);
        $display("tb_ibus_frame_channel_decoder_top: FAIL");
        $finish;
      end
    end
  end

  task automatic check_field(input string field, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
      fail_count++;
    end
  endtask

  // Output checker: each accepted item against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_channels.size() == 0) begin
        $error("unexpected item: chan %0d value %0d status %0d",
               channel_index_o, channel_value_o, status_o);
        fail_count++;
      end else begin
        head_item = pending_channels.pop_front();
        check_field("status", head_item.status, status_o);
        check_field("channel_index", head_item.chan, channel_index_o);
        check_field("channel_value", head_item.value, channel_value_o);
        check_field("last", head_item.last, last_o);
        items_checked++;
      end
    end
  end

  // Frame tracker: follows one accepted byte, queues the items it causes
  task automatic track_rx_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] prior;
    logic [15:0]       ck_word;
    logic [VAL_W-1:0]  v;
    int                y;
    prior   = rx_prev;
    rx_prev = b;
    if (prior == HDR_FIRST && b == HDR_SECOND) begin
      // header, also restarts an open frame
      frame_open = 1'b1;
      frame_pos  = 0;
      frame_sum  = CK_AFTER_HDR;
    end else if (frame_open) begin
      frame_bytes[frame_pos] = b;
      if (frame_pos < PAYLOAD_LEN) frame_sum = frame_sum - b;
      frame_pos++;
      if (frame_pos == FRAME_LEN) begin
        ck_word = {frame_bytes[FRAME_LEN-1], frame_bytes[FRAME_LEN-2]};
        if (ck_word != frame_sum) begin
          pending_channels.push_back('{status: 1'b1, chan: '0, value: '0, last: 1'b1});
          bad_frames++;
        end else begin
          for (int ch = 0; ch < PAIR_CHANNELS; ch++) begin
            v = {frame_bytes[2*ch+1][3:0], frame_bytes[2*ch]};
            pending_channels.push_back('{status: 1'b0, chan: CHAN_W'(ch), value: v,
                                         last: 1'b0});
          end
          // remaining channels gather high nibbles of three spread bytes
          for (int ch = PAIR_CHANNELS; ch < NUM_CHANNELS; ch++) begin
            y = 3 + 6 * (ch - PAIR_CHANNELS);
            v = {frame_bytes[y+2][7:4], frame_bytes[y][7:4], frame_bytes[y-2][7:4]};
            pending_channels.push_back('{status: 1'b0, chan: CHAN_W'(ch), value: v,
                                         last: (ch == NUM_CHANNELS - 1)});
          end
          good_frames++;
        end
        frame_open = 1'b0;
        frame_pos  = 0;
        frame_sum  = CK_INIT;
      end
    end
  endtask

  // Sender: optional idle gap, then offer the byte until it is taken
  task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    track_rx_byte(b);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_results_drained();
    release_input();
    while (pending_channels.size() != 0) @(posedge clk_i);
  endtask

  task automatic fill_payload_const(input logic [BYTE_W-1:0] b);
    foreach (payload_buf[i]) payload_buf[i] = b;
  endtask

  // random payload, leaning towards the byte extremes now and then
  task automatic fill_payload_random();
    int pick;
    foreach (payload_buf[i]) begin
      pick = $urandom_range(15);
      if (pick == 0) payload_buf[i] = 8'h00;
      else if (pick == 1) payload_buf[i] = 8'hFF;
      else payload_buf[i] = BYTE_W'($urandom_range(255));
    end
  endtask

  // Header, payload_buf and checksum word; a non-zero flip spoils the checksum
  task automatic send_frame(input logic [15:0] ck_flip);
    logic [15:0] ck;
    ck = CK_AFTER_HDR;
    foreach (payload_buf[i]) ck = ck - payload_buf[i];
    ck = ck ^ ck_flip;
    send_rx_byte(HDR_FIRST);
    send_rx_byte(HDR_SECOND);
    foreach (payload_buf[i]) send_rx_byte(payload_buf[i]);
    send_rx_byte(ck[7:0]);
    send_rx_byte(ck[15:8]);
  endtask

  // Mostly good frames, with bad checksums, cut-off frames and line noise
  task automatic random_traffic(input int goal);
    int start;
    int pick;
    int n;
    start = items_sent;
    while (items_sent - start < goal) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        fill_payload_random();
        send_frame('0);
      end else if (pick < 72) begin
        fill_payload_random();
        send_frame(16'($urandom_range(16'hFFFF, 1)));
      end else if (pick < 86) begin
        send_rx_byte(HDR_FIRST);
        send_rx_byte(HDR_SECOND);
        n = $urandom_range(PAYLOAD_LEN - 1);
        repeat (n) send_rx_byte(BYTE_W'($urandom_range(255)));
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          send_rx_byte(($urandom_range(3) == 0) ? HDR_FIRST : BYTE_W'($urandom_range(255)));
        end
      end
    end
  endtask

  // Directed: header byte after reset, stray bytes, value extremes,
  // checksum failure and a header arriving inside a frame
  task automatic test_directed_cases();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_rx_byte(HDR_SECOND);
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    fill_payload_const(8'hFF);
    send_frame('0);
    send_rx_byte(HDR_FIRST);
    fill_payload_const(8'h00);
    send_frame('0);
    fill_payload_random();
    send_frame(16'h0100);
    send_rx_byte(HDR_FIRST);
    send_rx_byte(HDR_SECOND);
    for (int i = 0; i < 10; i++) send_rx_byte(BYTE_W'(8'h55 + i));
    fill_payload_random();
    send_frame('0);
  endtask

  task automatic test_random_no_idle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    random_traffic(25);
  endtask

  task automatic test_random_sender_idle();
    src_idle_pct   = 70;
    sink_stall_pct = 0;
    random_traffic(25);
  endtask

  task automatic test_random_receiver_stall();
    src_idle_pct   = 0;
    sink_stall_pct = 70;
    random_traffic(25);
  endtask

  task automatic test_random_both_idle();
    src_idle_pct   = 22;
    sink_stall_pct = 22;
    random_traffic(25);
  endtask

  // Receiver holds off while frames keep coming, so the input backs up
  task automatic test_output_hold_off();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_requests++;
    fill_payload_random();
    send_frame('0);
    fill_payload_random();
    send_frame('0);
    fill_payload_random();
    send_frame(16'h8000);
  endtask

  // Sender waits for every outstanding item before the next frame
  task automatic test_drain_pause();
    src_idle_pct   = 30;
    sink_stall_pct = 30;
    fill_payload_random();
    send_frame('0);
    wait_results_drained();
    fill_payload_random();
    send_frame('0);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_output_hold_off();
    test_drain_pause();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_channels.size() != 0) begin
      $error("%0d expected items never arrived", pending_channels.size());
      fail_count++;
    end

    $display("Run covered %0d bytes: %0d good frames, %0d checksum failures,",
             items_sent, good_frames, bad_frames);
    $display("%0d output items checked, under idling, hold-off and drain phases",
             items_checked);
    if (fail_count == 0) begin
      $display("tb_ibus_frame_channel_decoder_top: PASS");
    end else begin
      $display("tb_ibus_frame_channel_decoder_top: FAIL");
    end
    $finish;
  end

endmodule
